[src/intruder_track_crossing_band_defines.svh]
// assertion macros for the intruder track crossing band
// used by the top level only, expects clk and arst_n in scope
`ifndef INTRUDER_TRACK_CROSSING_BAND_DEFINES_SVH
`define INTRUDER_TRACK_CROSSING_BAND_DEFINES_SVH

// same-cycle implication
`define ITCB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ITCB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/itcb_pkg.sv]
// shared constants, types and the arctangent table of the crossing band
// no dependencies
package itcb_pkg;

	localparam int STEPS    = 16;
	localparam int ZW       = 24;
	localparam int RW       = 33;
	localparam int VW       = 50;
	localparam int SQ_IN_W  = 56;
	localparam int SQ_OUT_W = 28;
	localparam int SQ_REM_W = 30;
	localparam int ROT_LAT  = STEPS;
	localparam int SQ_LAT   = SQ_OUT_W;
	localparam int VEC_LAT  = STEPS + 2;

	typedef logic signed [ZW-1:0] ang_t;
	typedef logic signed [RW-1:0] rot_t;
	typedef logic signed [VW-1:0] vec_t;

	localparam rot_t GAIN_Q30 = 33'sd652032874;

	localparam logic [14:0] FULL_TURN    = 15'd23040;
	localparam logic [14:0] HALF_TURN    = 15'd11520;
	localparam logic [14:0] QUARTER_TURN = 15'd5760;

	localparam ang_t HALF_TURN_FINE = 24'sd2949120;
	localparam logic signed [15:0] BEARING_MAX = 16'sd11520;

	localparam logic [1:0] CFG_LOOK_AHEAD = 2'd0;
	localparam logic [1:0] CFG_AVOID      = 2'd1;
	localparam logic [1:0] CFG_CAUTION    = 2'd2;

	localparam logic [1:0] ALERT_CLEAR   = 2'd0;
	localparam logic [1:0] ALERT_CAUTION = 2'd1;
	localparam logic [1:0] ALERT_AVOID   = 2'd2;

	// atan(2^-i) in 1/16384 degree
	function automatic ang_t atan_val(input logic [3:0] i);
		ang_t a;
		case (i)
			4'd0:  a = 24'sd737280;
			4'd1:  a = 24'sd435242;
			4'd2:  a = 24'sd229970;
			4'd3:  a = 24'sd116736;
			4'd4:  a = 24'sd58595;
			4'd5:  a = 24'sd29326;
			4'd6:  a = 24'sd14667;
			4'd7:  a = 24'sd7334;
			4'd8:  a = 24'sd3667;
			4'd9:  a = 24'sd1833;
			4'd10: a = 24'sd917;
			4'd11: a = 24'sd458;
			4'd12: a = 24'sd229;
			4'd13: a = 24'sd115;
			4'd14: a = 24'sd57;
			default: a = 24'sd29;
		endcase
		return a;
	endfunction

endpackage

[src/itcb_rotate.sv]
// pipelined rotation cordic, one micro-rotation per stage, q30 cos and sin
// depends on itcb_pkg
module itcb_rotate (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  itcb_pkg::ang_t    in_ang,
	output logic              out_valid,
	output itcb_pkg::rot_t    out_cos,
	output itcb_pkg::rot_t    out_sin
);

	itcb_pkg::rot_t x_s [itcb_pkg::STEPS];
	itcb_pkg::rot_t y_s [itcb_pkg::STEPS];
	itcb_pkg::ang_t z_s [itcb_pkg::STEPS];
	logic           v_s [itcb_pkg::STEPS];

	for (genvar i = 0; i < itcb_pkg::STEPS; i++) begin : g_step
		itcb_pkg::rot_t xp;
		itcb_pkg::rot_t yp;
		itcb_pkg::ang_t zp;
		logic           vp;

		if (i == 0) begin : g_first
			assign xp = itcb_pkg::GAIN_Q30;
			assign yp = '0;
			assign zp = in_ang;
			assign vp = in_valid;
		end else begin : g_next
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign vp = v_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i] <= 1'b0;
			end else if (en) begin
				v_s[i] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!zp[itcb_pkg::ZW-1]) begin
					x_s[i] <= xp - (yp >>> i);
					y_s[i] <= yp + (xp >>> i);
					z_s[i] <= zp - itcb_pkg::atan_val(4'(i));
				end else begin
					x_s[i] <= xp + (yp >>> i);
					y_s[i] <= yp - (xp >>> i);
					z_s[i] <= zp + itcb_pkg::atan_val(4'(i));
				end
			end
		end
	end

	assign out_valid = v_s[itcb_pkg::STEPS-1];
	assign out_cos   = x_s[itcb_pkg::STEPS-1];
	assign out_sin   = y_s[itcb_pkg::STEPS-1];

endmodule

[src/itcb_sqrt.sv]
// pipelined integer square root, one result bit per stage, floor result
// depends on itcb_pkg
module itcb_sqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  logic [itcb_pkg::SQ_IN_W-1:0]  in_rad,
	output logic                          out_valid,
	output logic [itcb_pkg::SQ_OUT_W-1:0] out_root
);

	localparam int N  = itcb_pkg::SQ_OUT_W;
	localparam int IW = itcb_pkg::SQ_IN_W;
	localparam int MW = itcb_pkg::SQ_REM_W;

	logic [IW-1:0] v_s    [N];
	logic [MW-1:0] rem_s  [N];
	logic [N-1:0]  root_s [N];
	logic          vld_s  [N];

	for (genvar i = 0; i < N; i++) begin : g_bit
		logic [IW-1:0] vp;
		logic [MW-1:0] remp;
		logic [N-1:0]  rootp;
		logic          vldp;
		logic [MW+1:0] rem_w;
		logic [MW+1:0] trial;
		logic          ge;

		if (i == 0) begin : g_first
			assign vp    = in_rad;
			assign remp  = '0;
			assign rootp = '0;
			assign vldp  = in_valid;
		end else begin : g_next
			assign vp    = v_s[i-1];
			assign remp  = rem_s[i-1];
			assign rootp = root_s[i-1];
			assign vldp  = vld_s[i-1];
		end

		// bring down the next two radicand bits and try root*4+1
		assign rem_w = {remp, vp[IW-1:IW-2]};
		assign trial = {(MW - N)'(0), rootp, 2'b01};
		assign ge    = (rem_w >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else if (en) begin
				vld_s[i] <= vldp;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				v_s[i]    <= {vp[IW-3:0], 2'b00};
				rem_s[i]  <= ge ? MW'(rem_w - trial) : MW'(rem_w);
				root_s[i] <= {rootp[N-2:0], ge};
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_root  = root_s[N-1];

endmodule

[src/itcb_vector.sv]
// pipelined vectoring cordic giving the bearing of a vector in 1/64 degree
// depends on itcb_pkg
module itcb_vector (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               in_valid,
	input  itcb_pkg::vec_t     in_x,
	input  itcb_pkg::vec_t     in_y,
	output logic               out_valid,
	output logic signed [14:0] out_bearing
);

	localparam int N = itcb_pkg::STEPS;

	itcb_pkg::vec_t x_s [N+1];
	itcb_pkg::vec_t y_s [N+1];
	itcb_pkg::ang_t z_s [N+1];
	logic           v_s [N+1];
	logic           zero_s [N+1];

	logic signed [14:0] bearing_q;
	logic               valid_q;

	// left half plane folds into the right with a half turn of offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s[0] <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			zero_s[0] <= (in_x == '0) && (in_y == '0);
			if (in_x[itcb_pkg::VW-1]) begin
				x_s[0] <= -in_x;
				y_s[0] <= -in_y;
				z_s[0] <= in_y[itcb_pkg::VW-1] ? -itcb_pkg::HALF_TURN_FINE
					: itcb_pkg::HALF_TURN_FINE;
			end else begin
				x_s[0] <= in_x;
				y_s[0] <= in_y;
				z_s[0] <= '0;
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else if (en) begin
				v_s[i+1] <= v_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_s[i+1] <= zero_s[i];
				if (y_s[i][itcb_pkg::VW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - itcb_pkg::atan_val(4'(i));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + itcb_pkg::atan_val(4'(i));
				end
			end
		end
	end

	itcb_pkg::ang_t     z_rnd;
	logic signed [15:0] z_deg;

	assign z_rnd = z_s[N] + 24'sd128;
	assign z_deg = z_rnd[itcb_pkg::ZW-1:8];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= v_s[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[N]) begin
				bearing_q <= '0;
			end else if (z_deg > itcb_pkg::BEARING_MAX) begin
				bearing_q <= 15'(itcb_pkg::BEARING_MAX);
			end else if (z_deg < -itcb_pkg::BEARING_MAX) begin
				bearing_q <= 15'(-itcb_pkg::BEARING_MAX);
			end else begin
				bearing_q <= 15'(z_deg);
			end
		end
	end

	assign out_valid   = valid_q;
	assign out_bearing = bearing_q;

endmodule

[src/intruder_track_crossing_band.sv]
// top level of the intruder track crossing band: line and circle crossing bearings
// depends on itcb_pkg, itcb_rotate, itcb_sqrt, itcb_vector and the defines header
//
//  channel   | handshake               | payload
//  ----------+-------------------------+-----------------------------------------
//  input     | in_valid / in_ready     | own_x own_y intruder_x intruder_y own_speed
//            |                         | intruder_heading
//  output    | out_valid / out_ready   | start_bearing end_bearing alert_level
//  config    | cfg_we                  | cfg_index cfg_data
//
// one request per cycle unless the pipeline holds
// latency is set by the two 16-step cordic pipelines and the 28-step root pipeline
// arst_n clears all valid bits and loads the register reset values
// the whole pipeline holds only when its last stage and the output register are both full
`include "intruder_track_crossing_band_defines.svh"

module intruder_track_crossing_band (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [23:0] own_x,
	input  logic signed [23:0] own_y,
	input  logic signed [23:0] intruder_x,
	input  logic signed [23:0] intruder_y,
	input  logic [15:0]        own_speed,
	input  logic [14:0]        intruder_heading,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [14:0] start_bearing,
	output logic signed [14:0] end_bearing,
	output logic [1:0]         alert_level,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [23:0]        cfg_data
);

	typedef struct packed {
		logic signed [24:0] dx;
		logic signed [24:0] dy;
		logic [15:0]        spd;
		logic               neg;
	} rot_side_t;

	typedef struct packed {
		logic signed [30:0] e;
		logic signed [17:0] ch;
		logic signed [17:0] sh;
		logic [1:0]         alert;
		logic               hit;
	} sq_side_t;

	typedef struct packed {
		logic [1:0] alert;
		logic       hit;
	} vec_side_t;

	logic [11:0] look_ahead_q;
	logic [23:0] avoid_q;
	logic [23:0] caution_q;

	logic en;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			look_ahead_q <= 12'd480;
			avoid_q      <= 24'd5000;
			caution_q    <= 24'd20000;
		end else if (cfg_we) begin
			case (cfg_index)
				itcb_pkg::CFG_LOOK_AHEAD: look_ahead_q <= cfg_data[11:0];
				itcb_pkg::CFG_AVOID:      avoid_q      <= cfg_data;
				itcb_pkg::CFG_CAUTION:    caution_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: heading fold into +-90 degrees, position difference
	logic [14:0]        hd_w;
	logic signed [15:0] hr_w;
	logic               neg_w;

	always_comb begin
		hd_w  = (intruder_heading >= itcb_pkg::FULL_TURN) ?
			intruder_heading - itcb_pkg::FULL_TURN : intruder_heading;
		neg_w = 1'b0;
		if (hd_w <= itcb_pkg::QUARTER_TURN) begin
			hr_w = $signed({1'b0, hd_w});
		end else if (hd_w < itcb_pkg::FULL_TURN - itcb_pkg::QUARTER_TURN) begin
			hr_w  = $signed({1'b0, hd_w}) - $signed({1'b0, itcb_pkg::HALF_TURN});
			neg_w = 1'b1;
		end else begin
			hr_w = $signed({1'b0, hd_w}) - $signed({1'b0, itcb_pkg::FULL_TURN});
		end
	end

	logic           v_s1;
	itcb_pkg::ang_t z_s1;
	rot_side_t      side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1        <= itcb_pkg::ang_t'(hr_w) <<< 8;
			side_s1.dx  <= {intruder_x[23], intruder_x} - {own_x[23], own_x};
			side_s1.dy  <= {intruder_y[23], intruder_y} - {own_y[23], own_y};
			side_s1.spd <= own_speed;
			side_s1.neg <= neg_w;
		end
	end

	logic           rot_v;
	itcb_pkg::rot_t rot_c;
	itcb_pkg::rot_t rot_s;

	itcb_rotate u_rotate (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s1),
		.in_ang    (z_s1),
		.out_valid (rot_v),
		.out_cos   (rot_c),
		.out_sin   (rot_s)
	);

	rot_side_t rot_d [itcb_pkg::ROT_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			rot_d[0] <= side_s1;
			for (int k = 1; k < itcb_pkg::ROT_LAT; k++) begin
				rot_d[k] <= rot_d[k-1];
			end
		end
	end

	rot_side_t rot_o;
	assign rot_o = rot_d[itcb_pkg::ROT_LAT-1];

	// stage 2: restore sign and round q30 to q16
	itcb_pkg::rot_t     cqn;
	itcb_pkg::rot_t     sqn;
	logic signed [33:0] cr;
	logic signed [33:0] sr;

	assign cqn = rot_o.neg ? -rot_c : rot_c;
	assign sqn = rot_o.neg ? -rot_s : rot_s;
	assign cr  = cqn + 34'sd8192;
	assign sr  = sqn + 34'sd8192;

	logic               v_s2;
	logic signed [17:0] ch_s2;
	logic signed [17:0] sh_s2;
	logic signed [24:0] dx_s2;
	logic signed [24:0] dy_s2;
	logic [15:0]        spd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= rot_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ch_s2  <= cr[31:14];
			sh_s2  <= sr[31:14];
			dx_s2  <= rot_o.dx;
			dy_s2  <= rot_o.dy;
			spd_s2 <= rot_o.spd;
		end
	end

	// stage 3: products for the line distance, radius and squared distances
	logic               v_s3;
	logic signed [42:0] sdx_s3;
	logic signed [42:0] cdy_s3;
	logic signed [49:0] dxx_s3;
	logic signed [49:0] dyy_s3;
	logic [27:0]        r_s3;
	logic [47:0]        av2_s3;
	logic [47:0]        ca2_s3;
	logic signed [17:0] ch_s3;
	logic signed [17:0] sh_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sdx_s3 <= sh_s2 * dx_s2;
			cdy_s3 <= ch_s2 * dy_s2;
			dxx_s3 <= dx_s2 * dx_s2;
			dyy_s3 <= dy_s2 * dy_s2;
			r_s3   <= 28'(spd_s2) * 28'(look_ahead_q);
			av2_s3 <= 48'(avoid_q) * 48'(avoid_q);
			ca2_s3 <= 48'(caution_q) * 48'(caution_q);
			ch_s3  <= ch_s2;
			sh_s3  <= sh_s2;
		end
	end

	// stage 4: line distance in 1/16 dm, squared radius, alert level
	logic signed [43:0] t_w;
	logic [50:0]        d2_w;
	logic [1:0]         alert_w;

	assign t_w  = cdy_s3 - sdx_s3 + 44'sd2048;
	assign d2_w = 51'(dxx_s3) + 51'(dyy_s3);

	always_comb begin
		if (d2_w > 51'(av2_s3) && d2_w <= 51'(ca2_s3)) begin
			alert_w = itcb_pkg::ALERT_CAUTION;
		end else if (d2_w <= 51'(av2_s3)) begin
			alert_w = itcb_pkg::ALERT_AVOID;
		end else begin
			alert_w = itcb_pkg::ALERT_CLEAR;
		end
	end

	logic               v_s4;
	logic signed [30:0] e_s4;
	logic [55:0]        r2_s4;
	logic [1:0]         alert_s4;
	logic signed [17:0] ch_s4;
	logic signed [17:0] sh_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_s4     <= t_w[42:12];
			r2_s4    <= 56'(r_s3) * 56'(r_s3);
			alert_s4 <= alert_w;
			ch_s4    <= ch_s3;
			sh_s4    <= sh_s3;
		end
	end

	// stage 5: squared line distance
	logic               v_s5;
	logic signed [61:0] e2_s5;
	logic [55:0]        r2_s5;
	logic signed [30:0] e_s5;
	logic [1:0]         alert_s5;
	logic signed [17:0] ch_s5;
	logic signed [17:0] sh_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e2_s5    <= e_s4 * e_s4;
			r2_s5    <= r2_s4;
			e_s5     <= e_s4;
			alert_s5 <= alert_s4;
			ch_s5    <= ch_s4;
			sh_s5    <= sh_s4;
		end
	end

	// stage 6: does the track line reach the circle
	logic        hit_w;
	logic        v_s6;
	logic [55:0] diff_s6;
	sq_side_t    side_s6;

	assign hit_w = ($unsigned(e2_s5) <= {6'b0, r2_s5});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s6       <= hit_w ? r2_s5 - 56'($unsigned(e2_s5)) : '0;
			side_s6.e     <= e_s5;
			side_s6.ch    <= ch_s5;
			side_s6.sh    <= sh_s5;
			side_s6.alert <= alert_s5;
			side_s6.hit   <= hit_w;
		end
	end

	logic        sq_v;
	logic [27:0] sq_root;

	itcb_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s6),
		.in_rad    (diff_s6),
		.out_valid (sq_v),
		.out_root  (sq_root)
	);

	sq_side_t sq_d [itcb_pkg::SQ_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_d[0] <= side_s6;
			for (int k = 1; k < itcb_pkg::SQ_LAT; k++) begin
				sq_d[k] <= sq_d[k-1];
			end
		end
	end

	sq_side_t sq_o;
	logic signed [29:0] e_t;
	logic signed [28:0] s_t;

	assign sq_o = sq_d[itcb_pkg::SQ_LAT-1];
	// a crossing bounds |e| by the radius, so 30 bits carry it
	assign e_t  = sq_o.e[29:0];
	assign s_t  = {1'b0, sq_root};

	// stage 7: crossing offset products
	logic               v_s7;
	logic signed [47:0] she_s7;
	logic signed [47:0] che_s7;
	logic signed [46:0] chs_s7;
	logic signed [46:0] shs_s7;
	vec_side_t          side_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= sq_v;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			she_s7        <= sq_o.sh * e_t;
			che_s7        <= sq_o.ch * e_t;
			chs_s7        <= sq_o.ch * s_t;
			shs_s7        <= sq_o.sh * s_t;
			side_s7.alert <= sq_o.alert;
			side_s7.hit   <= sq_o.hit;
		end
	end

	// stage 8: the two crossing offsets from the ownship
	logic           v_s8;
	itcb_pkg::vec_t x1_s8;
	itcb_pkg::vec_t y1_s8;
	itcb_pkg::vec_t x2_s8;
	itcb_pkg::vec_t y2_s8;
	vec_side_t      side_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x1_s8   <= -she_s7 - chs_s7;
			y1_s8   <= che_s7 - shs_s7;
			x2_s8   <= -she_s7 + chs_s7;
			y2_s8   <= che_s7 + shs_s7;
			side_s8 <= side_s7;
		end
	end

	logic               b1_v;
	logic               b2_v;
	logic signed [14:0] b1;
	logic signed [14:0] b2;

	itcb_vector u_vector_a (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (v_s8),
		.in_x        (x1_s8),
		.in_y        (y1_s8),
		.out_valid   (b1_v),
		.out_bearing (b1)
	);

	itcb_vector u_vector_b (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (en),
		.in_valid    (v_s8),
		.in_x        (x2_s8),
		.in_y        (y2_s8),
		.out_valid   (b2_v),
		.out_bearing (b2)
	);

	vec_side_t vec_d [itcb_pkg::VEC_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			vec_d[0] <= side_s8;
			for (int k = 1; k < itcb_pkg::VEC_LAT; k++) begin
				vec_d[k] <= vec_d[k-1];
			end
		end
	end

	vec_side_t vec_o;
	assign vec_o = vec_d[itcb_pkg::VEC_LAT-1];

	// output register
	logic               out_valid_q;
	logic signed [14:0] start_q;
	logic signed [14:0] end_q;
	logic [1:0]         alert_q;
	logic               out_load;

	// the output register takes a new request only when empty or being drained
	assign out_load = !out_valid_q || out_ready;
	assign en       = !b1_v || out_load;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= b1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && b1_v) begin
			alert_q <= vec_o.alert;
			if (!vec_o.hit) begin
				start_q <= '0;
				end_q   <= '0;
			end else if (b1 < b2) begin
				start_q <= b1;
				end_q   <= b2;
			end else begin
				start_q <= b2;
				end_q   <= b1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign start_bearing = start_q;
	assign end_bearing   = end_q;
	assign alert_level   = alert_q;

	`ITCB_ASSERT_NOW(a_ready_when_empty, !out_valid_q, in_ready, "input stalled with empty output")
	`ITCB_ASSERT_NOW(a_lanes_aligned, b1_v != b2_v, 1'b0, "bearing lanes out of step")
	`ITCB_ASSERT_NOW(a_band_order, out_valid_q, start_q <= end_q, "crossing band out of order")
	`ITCB_ASSERT_NOW(a_alert_code, out_valid_q, alert_q != 2'd3, "alert level code invalid")

endmodule

[bench/intruder_track_crossing_band_tb.sv]
// self-checking bench for the intruder track crossing band
// depends on itcb_pkg and the intruder_track_crossing_band top level
// random and directed aircraft pairs, bearings and alert checked against a local model
`timescale 1ns / 1ps

module intruder_track_crossing_band_tb;

	localparam logic [1:0] CFG_SPARE = 2'd3;
	localparam longint ATAN_FINE [16] = '{737280, 435242, 229970, 116736, 58595, 29326,
		14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};

	typedef struct {
		logic signed [23:0] ox, oy, ix, iy;
		logic [15:0] spd;
		logic [14:0] hdg;
	} pair_t;

	typedef struct {
		logic signed [14:0] lo, hi;
		logic [1:0] alert;
	} band_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [23:0] own_x = 0, own_y = 0, intruder_x = 0, intruder_y = 0;
	logic [15:0] own_speed = 0;
	logic [14:0] intruder_heading = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [14:0] start_bearing, end_bearing;
	logic [1:0] alert_level;
	logic cfg_we = 0;
	logic [1:0] cfg_index = 0;
	logic [23:0] cfg_data = 0;

	intruder_track_crossing_band dut (.*);

	always #1 clk = ~clk;

	// configuration copy used by the predictor
	longint unsigned look_ahead = 480, avoid_r = 5000, caution_r = 20000;

	pair_t pending[$];
	band_t band_q[$];
	pair_t cur;
	int send_gap = 0, recv_gap = 0, hold_cnt = 0, results = 0, errors = 0;
	bit burst = 0, held = 0;

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, bit_v;
		root = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > v) bit_v >>= 2;
		while (bit_v != 0) begin
			if (v >= root + bit_v) begin
				v -= root + bit_v;
				root = (root >> 1) + bit_v;
			end else begin
				root >>= 1;
			end
			bit_v >>= 2;
		end
		return root;
	endfunction

	function automatic longint bearing_of(longint x, longint y);
		longint z, xs, ys, r;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? 64'sd2949120 : -64'sd2949120;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y < 0) begin
				x -= ys; y += xs; z -= ATAN_FINE[i];
			end else begin
				x += ys; y -= xs; z += ATAN_FINE[i];
			end
		end
		r = (z + 128) >>> 8;
		if (r > 11520) r = 11520;
		if (r < -11520) r = -11520;
		return r;
	endfunction

	function automatic band_t predict_band(pair_t p);
		band_t b;
		longint dx, dy, hd, hr, x, y, z, xs, ys, ch, sh, t, e, s, b1, b2;
		longint unsigned r, r2, e2, d2;
		bit neg;
		dx = longint'(p.ix) - longint'(p.ox);
		dy = longint'(p.iy) - longint'(p.oy);
		hd = p.hdg;
		neg = 0;
		if (hd >= 23040) hd -= 23040;
		if (hd <= 5760) hr = hd;
		else if (hd < 17280) begin
			hr = hd - 11520;
			neg = 1;
		end else hr = hd - 23040;
		x = 652032874;
		y = 0;
		z = hr * 256;
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= ATAN_FINE[i];
			end else begin
				x += ys; y -= xs; z += ATAN_FINE[i];
			end
		end
		if (neg) begin
			x = -x;
			y = -y;
		end
		ch = (x + 8192) >>> 14;
		sh = (y + 8192) >>> 14;
		t = -sh * dx + ch * dy;
		e = (t + 2048) >>> 12;
		r = longint'(p.spd) * look_ahead;
		r2 = r * r;
		e2 = (e < 0) ? -e : e;
		e2 = e2 * e2;
		b.lo = 0;
		b.hi = 0;
		if (e2 <= r2) begin
			s = int_sqrt(r2 - e2);
			b1 = bearing_of(-sh * e - ch * s, ch * e - sh * s);
			b2 = bearing_of(-sh * e + ch * s, ch * e + sh * s);
			b.lo = (b1 < b2) ? b1 : b2;
			b.hi = (b1 < b2) ? b2 : b1;
		end
		d2 = dx * dx + dy * dy;
		if (d2 > avoid_r * avoid_r && d2 <= caution_r * caution_r)
			b.alert = itcb_pkg::ALERT_CAUTION;
		else if (d2 <= avoid_r * avoid_r) b.alert = itcb_pkg::ALERT_AVOID;
		else b.alert = itcb_pkg::ALERT_CLEAR;
		return b;
	endfunction

	// sender
	always @(posedge clk) begin
		bit nv;
		nv = in_valid;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				band_q.push_back(predict_band(cur));
				nv = 0;
			end
			if (!nv) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
				end else if (pending.size() > 0) begin
					cur = pending.pop_front();
					own_x <= cur.ox;
					own_y <= cur.oy;
					intruder_x <= cur.ix;
					intruder_y <= cur.iy;
					own_speed <= cur.spd;
					intruder_heading <= cur.hdg;
					nv = 1;
					if ($urandom_range(0, 39) == 0) burst = ~burst;
					send_gap <= burst ? 0 : $urandom_range(0, 5);
				end
			end
		end
		in_valid <= nv;
	end

	// receiver and checker
	always @(posedge clk) begin
		band_t want;
		bit nr;
		nr = out_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results++;
				nr = 0;
				if (band_q.size() == 0) begin
					errors++;
					if (errors <= 10) $display("unexpected result %0d %0d %0d",
						start_bearing, end_bearing, alert_level);
				end else begin
					want = band_q.pop_front();
					if (want.lo !== start_bearing || want.hi !== end_bearing ||
					    want.alert !== alert_level) begin
						errors++;
						if (errors <= 10)
							$display("mismatch: exp %0d %0d %0d got %0d %0d %0d",
								want.lo, want.hi, want.alert,
								start_bearing, end_bearing, alert_level);
					end
				end
				if (results == 150 && !held) begin
					held = 1;
					hold_cnt <= 400;
				end else recv_gap <= burst ? 0 : $urandom_range(0, 5);
			end else if (!nr) begin
				if (hold_cnt > 0) hold_cnt <= hold_cnt - 1;
				else if (recv_gap > 0) recv_gap <= recv_gap - 1;
				else nr = 1;
			end
		end
		out_ready <= nr;
	end

	task automatic write_reg(logic [1:0] idx, logic [23:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		case (idx)
			itcb_pkg::CFG_LOOK_AHEAD: look_ahead = val[11:0];
			itcb_pkg::CFG_AVOID:      avoid_r = val;
			itcb_pkg::CFG_CAUTION:    caution_r = val;
			default: ;
		endcase
	endtask

	task automatic drain;
		while (pending.size() > 0 || in_valid || band_q.size() > 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic pair_t mk(int ox, int oy, int ix, int iy, int spd, int hdg);
		pair_t p;
		p.ox = ox; p.oy = oy; p.ix = ix; p.iy = iy; p.spd = spd; p.hdg = hdg;
		return p;
	endfunction

	function automatic pair_t rand_pair();
		pair_t p;
		int span;
		p.spd = $urandom_range(0, 9) == 0 ? $urandom : $urandom_range(0, 400);
		p.hdg = $urandom_range(0, 15) == 0 ? $urandom_range(23040, 32767)
			: $urandom_range(0, 23039);
		if ($urandom_range(0, 4) == 0) begin
			p.ox = $urandom; p.oy = $urandom; p.ix = $urandom; p.iy = $urandom;
		end else begin
			// mostly near pairs so the track crosses the circle
			span = $urandom_range(0, 3) == 0 ? 1000000 : 30000;
			p.ox = $urandom_range(0, 2000000) - 1000000;
			p.oy = $urandom_range(0, 2000000) - 1000000;
			p.ix = p.ox + $urandom_range(0, 2 * span) - span;
			p.iy = p.oy + $urandom_range(0, 2 * span) - span;
		end
		return p;
	endfunction

	task automatic random_phase(int n);
		repeat (n) pending.push_back(rand_pair());
		drain();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes, cardinal headings, tangent, zero offset, heading wrap
		pending.push_back(mk(0, 0, 0, 0, 0, 0));
		pending.push_back(mk(0, 0, 0, 3000, 100, 0));
		pending.push_back(mk(0, 0, 3000, 0, 100, 5760));
		pending.push_back(mk(0, 0, 100, 200, 100, 11520));
		pending.push_back(mk(0, 0, -100, 50, 100, 17280));
		pending.push_back(mk(0, 0, 500, 500, 100, 23039));
		pending.push_back(mk(0, 0, 500, 500, 100, 23040));
		pending.push_back(mk(0, 0, 500, 500, 100, 32767));
		pending.push_back(mk(-8388608, -8388608, 8388607, 8388607, 65535, 2880));
		pending.push_back(mk(8388607, 8388607, -8388608, -8388608, 65535, 20000));
		pending.push_back(mk(8388607, -8388608, -8388608, 8388607, 0, 1000));
		pending.push_back(mk(0, 0, 5000, 0, 50, 300));
		pending.push_back(mk(0, 0, 5001, 0, 50, 300));
		pending.push_back(mk(0, 0, 20000, 0, 50, 300));
		pending.push_back(mk(0, 0, 0, 20001, 50, 300));
		pending.push_back(mk(10, 10, 10, 10, 0, 7000));
		pending.push_back(mk(-5, 7, 20000, -40000, 65535, 14000));
		drain();
		random_phase(250);
		write_reg(itcb_pkg::CFG_LOOK_AHEAD, 0);
		write_reg(itcb_pkg::CFG_AVOID, 0);
		write_reg(itcb_pkg::CFG_CAUTION, 0);
		random_phase(120);
		write_reg(itcb_pkg::CFG_LOOK_AHEAD, 24'hFFF);
		write_reg(itcb_pkg::CFG_AVOID, 24'hFFFFFF);
		write_reg(itcb_pkg::CFG_CAUTION, 24'hFFFFFF);
		random_phase(180);
		// avoid at or above caution
		write_reg(itcb_pkg::CFG_LOOK_AHEAD, 24'h123FFF);
		write_reg(itcb_pkg::CFG_AVOID, 30000);
		write_reg(itcb_pkg::CFG_CAUTION, 10000);
		random_phase(180);
		write_reg(CFG_SPARE, 24'hABCDEF);
		random_phase(60);
		write_reg(itcb_pkg::CFG_LOOK_AHEAD, $urandom_range(1, 4095));
		write_reg(itcb_pkg::CFG_AVOID, $urandom_range(0, 200000));
		write_reg(itcb_pkg::CFG_CAUTION, $urandom_range(0, 800000));
		random_phase(300);
		if (errors == 0 && band_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

[intruder_track_crossing_band.f]
+incdir+src
src/itcb_pkg.sv
src/itcb_rotate.sv
src/itcb_sqrt.sv
src/itcb_vector.sv
src/intruder_track_crossing_band.sv
bench/intruder_track_crossing_band_tb.sv
